// ===== design/sxlt_pkg.sv =====
// Package for the shared/exclusive lock table: sizes, codes and beat payload types.
`default_nettype none
package sxlt_pkg;
	localparam int HELD_DEPTH  = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int NAME_BITS   = 10;
	localparam int ID_BITS     = 16;

	localparam int SCAN_MAX = (HELD_DEPTH > QUEUE_DEPTH) ? HELD_DEPTH : QUEUE_DEPTH;
	localparam int CNT_W    = $clog2(SCAN_MAX + 1);
	localparam int HIDX_W   = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
	localparam int WIDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [1:0] FUNC_REQUEST = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_ABORT   = 2'd2;
	localparam logic [1:0] FUNC_QUERY   = 2'd3;

	localparam logic [1:0] WAIT_QUEUE   = 2'd0;
	localparam logic [1:0] WAIT_NO_WAIT = 2'd1;
	localparam logic [1:0] WAIT_PREEMPT = 2'd2;

	localparam logic MODE_EXCLUSIVE = 1'b1;

	localparam logic [2:0] KIND_GRANTED = 3'd0;
	localparam logic [2:0] KIND_FAILED  = 3'd1;
	localparam logic [2:0] KIND_QUEUED  = 3'd2;
	localparam logic [2:0] KIND_HELD    = 3'd3;
	localparam logic [2:0] KIND_WAITING = 3'd4;
	localparam logic [2:0] KIND_FULL    = 3'd5;
	localparam logic [2:0] KIND_DONE    = 3'd6;

	typedef struct packed {
		logic [1:0]  func;
		logic [9:0]  lock_name;
		logic        lock_mode;
		logic [1:0]  wait_mode;
		logic [7:0]  requester_tag;
		logic [15:0] handle_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  out_tag;
		logic [15:0] out_id;
		logic [9:0]  out_name;
		logic        out_mode;
		logic        last;
	} rsp_t;

	// compare unit outputs
	typedef struct packed {
		logic name_eq;
		logic conflict;
		logic id_eq;
	} cmp_t;
endpackage
`default_nettype wire

// ===== design/sxlt_if.sv =====
// Valid/ready channel interfaces for request and response beats.
`default_nettype none
interface sxlt_req_if;
	logic         valid;
	logic         ready;
	sxlt_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sxlt_rsp_if;
	logic         valid;
	logic         ready;
	sxlt_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/sxlt_cmp.sv =====
// Shared compare unit: key against one table entry.
`default_nettype none
module sxlt_cmp (
	input  wire logic [sxlt_pkg::NAME_BITS-1:0] key_name,
	input  wire logic                           key_mode,
	input  wire logic [sxlt_pkg::ID_BITS-1:0]   key_id,
	input  wire logic [sxlt_pkg::NAME_BITS-1:0] ent_name,
	input  wire logic                           ent_mode,
	input  wire logic [sxlt_pkg::ID_BITS-1:0]   ent_id,
	output sxlt_pkg::cmp_t                      res
);
	always_comb begin
		res.name_eq  = (key_name == ent_name);
		res.conflict = (key_name == ent_name) &&
			((key_mode == sxlt_pkg::MODE_EXCLUSIVE) || (ent_mode == sxlt_pkg::MODE_EXCLUSIVE));
		res.id_eq    = (key_id == ent_id);
	end
endmodule
`default_nettype wire

// ===== design/shared_exclusive_lock_table_top.sv =====
// Top level of the shared/exclusive lock table with FIFO wait queue.
// Usage:
//  req carries one command beat: request, release, abort or query.
//  rsp carries result beats; last marks the final beat of a command.
//  req.ready is high only while the sequencer is idle; one command at a time.
//  Every search walk goes one entry per cycle through the single compare unit.
//  Request: preempt walk (preempt mode only), held walk and queue walk, then
//  the answer. Release/abort: find walk, then the rescan: for waiter i a load,
//  a duplicate-name walk over the waiters ahead of it and a held walk; a grant
//  restarts the rescan from the head; a final load and the done beat end it.
//  Query: one beat per held entry, then per waiting entry; a lone done beat if both are empty.
//  One output register holds a result; while it holds a beat and rsp.ready is low
//  the sequencer waits before producing the next beat, so no beat is lost or repeated.
//  Reset empties both tables, sets the next id to one and clears rsp.valid.
`default_nettype none
module shared_exclusive_lock_table_top (
	input wire logic  clk,
	input wire logic  arst_n,
	sxlt_req_if.sink  req,
	sxlt_rsp_if.source rsp
);
	localparam int HD = sxlt_pkg::HELD_DEPTH;
	localparam int QD = sxlt_pkg::QUEUE_DEPTH;
	localparam int CW = sxlt_pkg::CNT_W;
	localparam int NB = sxlt_pkg::NAME_BITS;
	localparam int IB = sxlt_pkg::ID_BITS;
	localparam int HW = sxlt_pkg::HIDX_W;
	localparam int WW = sxlt_pkg::WIDX_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_PRE     = 4'd1;
	localparam logic [3:0] ST_GH      = 4'd2;
	localparam logic [3:0] ST_GW      = 4'd3;
	localparam logic [3:0] ST_DEC     = 4'd4;
	localparam logic [3:0] ST_FIND    = 4'd5;
	localparam logic [3:0] ST_RS_LOAD = 4'd6;
	localparam logic [3:0] ST_RS_DUP  = 4'd7;
	localparam logic [3:0] ST_RS_HELD = 4'd8;
	localparam logic [3:0] ST_RS_GNT  = 4'd9;
	localparam logic [3:0] ST_DONE    = 4'd10;
	localparam logic [3:0] ST_Q_HELD  = 4'd11;
	localparam logic [3:0] ST_Q_WAIT  = 4'd12;

	logic [NB-1:0] h_name [HD];
	logic          h_mode [HD];
	logic [IB-1:0] h_id   [HD];
	logic [NB-1:0] w_name [QD];
	logic          w_mode [QD];
	logic [IB-1:0] w_id   [QD];
	logic [7:0]    w_tag  [QD];

	logic [CW-1:0] h_cnt_q, w_cnt_q, i_q, j_q;
	logic [3:0]    state_q;
	logic [IB-1:0] next_id_q;
	logic          conflict_q;

	logic [1:0]    k_func_q, k_wait_q;
	logic [NB-1:0] k_name_q;
	logic          k_mode_q;
	logic [7:0]    k_tag_q;
	logic [15:0]   k_hid_q;

	logic [NB-1:0] c_name_q;
	logic          c_mode_q;
	logic [7:0]    c_tag_q;

	logic          o_valid_q;
	sxlt_pkg::rsp_t o_data_q;

	// sequencer controls
	logic          slot_free;
	logic          emit;
	sxlt_pkg::rsp_t emit_data;
	logic          h_rm, h_add, w_rm, w_add;
	logic [CW-1:0] h_rm_idx, w_rm_idx;
	logic [NB-1:0] add_name;
	logic          add_mode;
	logic [3:0]    state_d;
	logic [CW-1:0] i_d, j_d, h_cnt_d, w_cnt_d;
	logic          conflict_d, take_id, load_cur;

	logic [HW-1:0] hidx;
	logic [WW-1:0] widx;
	logic [NB-1:0] hr_name, wr_name;
	logic          hr_mode, wr_mode;
	logic [IB-1:0] hr_id, wr_id;
	logic [7:0]    wr_tag;
	logic          rescan_st, held_st;
	sxlt_pkg::cmp_t cmp;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = o_valid_q;
	assign rsp.data  = o_data_q;
	assign slot_free = !o_valid_q || rsp.ready;

	assign hidx = j_q[HW-1:0];
	assign widx = (state_q == ST_RS_LOAD || state_q == ST_RS_GNT) ? i_q[WW-1:0] : j_q[WW-1:0];
	assign hr_name = h_name[hidx];
	assign hr_mode = h_mode[hidx];
	assign hr_id   = h_id[hidx];
	assign wr_name = w_name[widx];
	assign wr_mode = w_mode[widx];
	assign wr_id   = w_id[widx];
	assign wr_tag  = w_tag[widx];

	assign rescan_st = (state_q == ST_RS_DUP) || (state_q == ST_RS_HELD);
	assign held_st = (state_q == ST_PRE) || (state_q == ST_GH) || (state_q == ST_RS_HELD) ||
		(state_q == ST_Q_HELD) || ((state_q == ST_FIND) && (k_func_q == sxlt_pkg::FUNC_RELEASE));

	sxlt_cmp u_cmp (
		.key_name (rescan_st ? c_name_q : k_name_q),
		.key_mode (rescan_st ? c_mode_q : k_mode_q),
		.key_id   (k_hid_q[IB-1:0]),
		.ent_name (held_st ? hr_name : wr_name),
		.ent_mode (held_st ? hr_mode : wr_mode),
		.ent_id   (held_st ? hr_id : wr_id),
		.res      (cmp)
	);

	always_comb begin
		state_d    = state_q;
		i_d        = i_q;
		j_d        = j_q;
		conflict_d = conflict_q;
		emit       = 1'b0;
		emit_data  = '0;
		h_rm = 1'b0; h_add = 1'b0; w_rm = 1'b0; w_add = 1'b0;
		h_rm_idx = j_q;
		w_rm_idx = j_q;
		add_name = k_name_q;
		add_mode = k_mode_q;
		take_id  = 1'b0;
		load_cur = 1'b0;
		case (state_q)
			ST_IDLE: begin
				j_d = '0;
				i_d = '0;
				conflict_d = 1'b0;
				if (req.valid) begin
					case (req.data.func)
						sxlt_pkg::FUNC_REQUEST:
							state_d = (req.data.wait_mode == sxlt_pkg::WAIT_PREEMPT) ? ST_PRE : ST_GH;
						sxlt_pkg::FUNC_RELEASE, sxlt_pkg::FUNC_ABORT: state_d = ST_FIND;
						default: state_d = ST_Q_HELD;
					endcase
				end
			end
			ST_PRE: begin
				if (j_q < h_cnt_q) begin
					if (cmp.name_eq) h_rm = 1'b1;
					else j_d = j_q + 1'b1;
				end else begin
					j_d = '0;
					state_d = ST_GH;
				end
			end
			ST_GH: begin
				if (j_q < h_cnt_q) begin
					if (cmp.conflict) conflict_d = 1'b1;
					j_d = j_q + 1'b1;
				end else begin
					j_d = '0;
					state_d = ST_GW;
				end
			end
			ST_GW: begin
				if (j_q < w_cnt_q) begin
					if (cmp.name_eq) conflict_d = 1'b1;
					j_d = j_q + 1'b1;
				end else begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (slot_free) begin
					emit = 1'b1;
					emit_data.out_tag  = k_tag_q;
					emit_data.out_name = k_name_q;
					emit_data.out_mode = k_mode_q;
					emit_data.last     = 1'b1;
					if (!conflict_q) begin
						if (h_cnt_q >= CW'(HD)) begin
							emit_data.result_kind = sxlt_pkg::KIND_FULL;
						end else begin
							emit_data.result_kind = sxlt_pkg::KIND_GRANTED;
							emit_data.out_id = 16'(next_id_q);
							h_add = 1'b1;
							take_id = 1'b1;
						end
					end else if (k_wait_q == sxlt_pkg::WAIT_NO_WAIT) begin
						emit_data.result_kind = sxlt_pkg::KIND_FAILED;
					end else if (w_cnt_q >= CW'(QD)) begin
						emit_data.result_kind = sxlt_pkg::KIND_FULL;
					end else begin
						emit_data.result_kind = sxlt_pkg::KIND_QUEUED;
						emit_data.out_id = 16'(next_id_q);
						w_add = 1'b1;
						take_id = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_FIND: begin
				if (k_func_q == sxlt_pkg::FUNC_RELEASE) begin
					if (j_q < h_cnt_q) begin
						if (cmp.id_eq) begin
							h_rm = 1'b1;
							state_d = ST_RS_LOAD;
						end
						j_d = j_q + 1'b1;
					end else state_d = ST_RS_LOAD;
				end else begin
					if (j_q < w_cnt_q) begin
						if (cmp.id_eq) begin
							w_rm = 1'b1;
							state_d = ST_RS_LOAD;
						end
						j_d = j_q + 1'b1;
					end else state_d = ST_RS_LOAD;
				end
				i_d = '0;
			end
			ST_RS_LOAD: begin
				j_d = '0;
				conflict_d = 1'b0;
				if ((h_cnt_q >= CW'(HD)) || (i_q >= w_cnt_q)) begin
					state_d = ST_DONE;
				end else begin
					load_cur = 1'b1;
					state_d = ST_RS_DUP;
				end
			end
			ST_RS_DUP: begin
				// only the first waiter of a name may be granted
				if (j_q < i_q) begin
					if (cmp.name_eq) begin
						i_d = i_q + 1'b1;
						state_d = ST_RS_LOAD;
					end
					j_d = j_q + 1'b1;
				end else begin
					j_d = '0;
					state_d = ST_RS_HELD;
				end
			end
			ST_RS_HELD: begin
				if (j_q < h_cnt_q) begin
					if (cmp.conflict) conflict_d = 1'b1;
					j_d = j_q + 1'b1;
				end else if (conflict_q) begin
					i_d = i_q + 1'b1;
					state_d = ST_RS_LOAD;
				end else begin
					state_d = ST_RS_GNT;
				end
			end
			ST_RS_GNT: begin
				if (slot_free) begin
					emit = 1'b1;
					emit_data.result_kind = sxlt_pkg::KIND_GRANTED;
					emit_data.out_tag  = c_tag_q;
					emit_data.out_id   = 16'(next_id_q);
					emit_data.out_name = c_name_q;
					emit_data.out_mode = c_mode_q;
					h_add = 1'b1;
					add_name = c_name_q;
					add_mode = c_mode_q;
					take_id = 1'b1;
					w_rm = 1'b1;
					w_rm_idx = i_q;
					i_d = '0;
					state_d = ST_RS_LOAD;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					emit = 1'b1;
					emit_data.result_kind = sxlt_pkg::KIND_DONE;
					emit_data.out_tag = k_tag_q;
					emit_data.out_id  = k_hid_q;
					emit_data.last    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_Q_HELD: begin
				if (j_q < h_cnt_q) begin
					if (slot_free) begin
						emit = 1'b1;
						emit_data.result_kind = sxlt_pkg::KIND_HELD;
						emit_data.out_tag  = k_tag_q;
						emit_data.out_id   = 16'(hr_id);
						emit_data.out_name = 10'(hr_name);
						emit_data.out_mode = hr_mode;
						emit_data.last = (j_q + 1'b1 == h_cnt_q) && (w_cnt_q == '0);
						j_d = j_q + 1'b1;
					end
				end else begin
					j_d = '0;
					state_d = ST_Q_WAIT;
				end
			end
			ST_Q_WAIT: begin
				if (j_q < w_cnt_q) begin
					if (slot_free) begin
						emit = 1'b1;
						emit_data.result_kind = sxlt_pkg::KIND_WAITING;
						emit_data.out_tag  = k_tag_q;
						emit_data.out_id   = 16'(wr_id);
						emit_data.out_name = 10'(wr_name);
						emit_data.out_mode = wr_mode;
						emit_data.last = (j_q + 1'b1 == w_cnt_q);
						j_d = j_q + 1'b1;
					end
				end else if (h_cnt_q == '0 && w_cnt_q == '0) begin
					// empty tables: a lone done beat
					if (slot_free) begin
						emit = 1'b1;
						emit_data.result_kind = sxlt_pkg::KIND_DONE;
						emit_data.out_tag = k_tag_q;
						emit_data.last = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		h_cnt_d = h_cnt_q - CW'(h_rm) + CW'(h_add);
		w_cnt_d = w_cnt_q - CW'(w_rm) + CW'(w_add);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			h_cnt_q    <= '0;
			w_cnt_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			conflict_q <= 1'b0;
			next_id_q  <= IB'(1);
			o_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			h_cnt_q    <= h_cnt_d;
			w_cnt_q    <= w_cnt_d;
			i_q        <= i_d;
			j_q        <= j_d;
			conflict_q <= conflict_d;
			if (take_id) next_id_q <= next_id_q + 1'b1;
			if (emit) o_valid_q <= 1'b1;
			else if (rsp.ready) o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) o_data_q <= emit_data;
		if (state_q == ST_IDLE && req.valid) begin
			k_func_q <= req.data.func;
			k_name_q <= req.data.lock_name[NB-1:0];
			k_mode_q <= req.data.lock_mode;
			k_wait_q <= req.data.wait_mode;
			k_tag_q  <= req.data.requester_tag;
			k_hid_q  <= req.data.handle_id;
		end
		if (load_cur) begin
			c_name_q <= wr_name;
			c_mode_q <= wr_mode;
			c_tag_q  <= wr_tag;
		end
		// held table: shift down over a removed entry, append at the tail
		for (int e = 0; e < HD; e++) begin
			if (h_rm && CW'(e) >= h_rm_idx && e < HD - 1) begin
				h_name[e] <= h_name[e+1];
				h_mode[e] <= h_mode[e+1];
				h_id[e]   <= h_id[e+1];
			end
			if (h_add && CW'(e) == h_cnt_q) begin
				h_name[e] <= add_name;
				h_mode[e] <= add_mode;
				h_id[e]   <= next_id_q;
			end
		end
		for (int e = 0; e < QD; e++) begin
			if (w_rm && CW'(e) >= w_rm_idx && e < QD - 1) begin
				w_name[e] <= w_name[e+1];
				w_mode[e] <= w_mode[e+1];
				w_id[e]   <= w_id[e+1];
				w_tag[e]  <= w_tag[e+1];
			end
			if (w_add && CW'(e) == w_cnt_q) begin
				w_name[e] <= k_name_q;
				w_mode[e] <= k_mode_q;
				w_id[e]   <= next_id_q;
				w_tag[e]  <= k_tag_q;
			end
		end
	end
endmodule
`default_nettype wire
